@@ design/setl_pkg.sv @@
// Shared types and codes for the sorted expiry timer list.
package setl_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int EXPIRY_W        = 32;
	localparam int IDENT_W         = 16;
	localparam int PEND_W          = 5;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_EXPIRED  = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_CMP_RD,
		S_CMP_CHK,
		S_TICK_RD,
		S_TICK_CHK,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic [EXPIRY_W-1:0] expiry;
		logic [IDENT_W-1:0]  ident;
	} setl_entry_t;

endpackage

@@ design/setl_ram.sv @@
// Single-write, single-read timer table storage with registered read data.
module setl_ram import setl_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  setl_entry_t   wr_data,
	input  logic [AW-1:0] rd_addr,
	output setl_entry_t   rd_data
);

	setl_entry_t mem_q [DEPTH];
	setl_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/sorted_expiry_timer_list.sv @@
// Top level of the sorted expiry timer list: sequencer, shared compare and result register.
//
// Keeps up to TABLE_DEPTH pending timers in a table ordered by expiry second;
// equal expiries stay in arrival order.
// Request channel (req_valid / req_stall): action, expiry_time, timer_id,
// now_seconds. A request is taken when req_valid is high and req_stall low.
// req_stall is high while a request is in work, so one request at a time.
// Result channel (res_valid / res_stall): status, expired_id, pending_count,
// exactly one result per request, held steady while res_stall is high.
// Each request walks the table through its one read port and one write port, doing
// a read then a write for each entry it moves:
//   insert : moves each entry with a later expiry up one slot, then writes the new one
//   cancel : reads every entry and compacts those whose id does not match
//   tick   : reads the head and, when it is due, shifts the rest down by one
//   full insert, empty tick, no-op : no table access
// The result register frees the sequencer once it is loaded; a stalled
// result only holds the next request in its final state until it is taken.
// Reset (arst_n low) empties the table and drops any pending result; table
// contents need no clearing since only entries below the count are read.
module sorted_expiry_timer_list import setl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          action,
	input  logic [EXPIRY_W-1:0] expiry_time,
	input  logic [IDENT_W-1:0]  timer_id,
	input  logic [EXPIRY_W-1:0] now_seconds,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [1:0]          status,
	output logic [IDENT_W-1:0]  expired_id,
	output logic [PEND_W-1:0]   pending_count
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	seq_state_t state_q, state_d;
	action_t    act_in;
	action_t    op_q;

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       pos_q;   // insert: entries still above the new slot
	logic [CW-1:0]       pos_m1;
	logic [CW-1:0]       rd_q;    // compaction read pointer
	logic [CW-1:0]       wr_q;    // compaction write pointer
	logic [EXPIRY_W-1:0] key_q;   // insert expiry or tick time
	logic [IDENT_W-1:0]  id_q;
	status_t             fin_status_q;
	logic [IDENT_W-1:0]  fin_id_q;

	logic                res_valid_q;
	status_t             res_status_q;
	logic [IDENT_W-1:0]  res_id_q;
	logic [PEND_W-1:0]   res_count_q;

	logic        req_take;
	logic        res_free;
	logic        cmp_gt;
	logic        drop;

	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	setl_entry_t ram_wdata;
	setl_entry_t ram_rdata;
	setl_entry_t new_entry;

	setl_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign act_in    = action_t'(action);
	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign pos_m1    = pos_q - 1'b1;

	// the one shared comparator: insert walks while entry > new expiry,
	// a tick expires the head when !(head > now)
	assign cmp_gt = (ram_rdata.expiry > key_q);
	assign drop   = (op_q == ACT_CANCEL) && (ram_rdata.ident == id_q);

	assign new_entry.expiry = key_q;
	assign new_entry.ident  = id_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					case (act_in)
						ACT_INSERT: state_d = (count_q >= DEPTH_C) ? S_FIN : S_INS_RD;
						ACT_CANCEL: state_d = S_CMP_RD;
						ACT_TICK:   state_d = (count_q == '0) ? S_FIN : S_TICK_RD;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_INS_RD:   state_d = (pos_q == '0) ? S_FIN : S_INS_CMP;
			S_INS_CMP:  state_d = cmp_gt ? S_INS_RD : S_FIN;
			S_CMP_RD:   state_d = (rd_q == count_q) ? S_FIN : S_CMP_CHK;
			S_CMP_CHK:  state_d = S_CMP_RD;
			S_TICK_RD:  state_d = S_TICK_CHK;
			S_TICK_CHK: state_d = cmp_gt ? S_FIN : S_CMP_RD;
			S_FIN:      state_d = res_free ? S_IDLE : S_FIN;
			default:    state_d = S_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = new_entry;
		ram_raddr = rd_q[AW-1:0];
		case (state_q)
			S_INS_RD: begin
				if (pos_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
				end else begin
					ram_raddr = pos_m1[AW-1:0];
				end
			end
			S_INS_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = cmp_gt ? ram_rdata : new_entry;
			end
			S_CMP_CHK: begin
				ram_we    = !drop;
				ram_waddr = wr_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_TICK_RD: ram_raddr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_INS_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_INS_CMP: begin
					if (!cmp_gt) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_CMP_RD: begin
					if (rd_q == count_q) begin
						count_q <= wr_q;
					end
				end
				default: ;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					op_q     <= act_in;
					key_q    <= (act_in == ACT_INSERT) ? expiry_time : now_seconds;
					id_q     <= timer_id;
					pos_q    <= count_q;
					rd_q     <= '0;
					wr_q     <= '0;
					fin_id_q <= '0;
					fin_status_q <= (act_in == ACT_INSERT && count_q >= DEPTH_C) ?
						ST_FULL : ST_NONE;
				end
			end
			S_INS_RD: begin
				if (pos_q == '0) begin
					fin_status_q <= ST_ACCEPTED;
				end
			end
			S_INS_CMP: begin
				if (cmp_gt) begin
					pos_q <= pos_m1;
				end else begin
					fin_status_q <= ST_ACCEPTED;
				end
			end
			S_CMP_RD: begin
				if (rd_q == count_q) begin
					if (op_q == ACT_TICK) begin
						fin_status_q <= ST_EXPIRED;
					end else begin
						fin_status_q <= (wr_q != count_q) ? ST_ACCEPTED : ST_NONE;
					end
				end
			end
			S_CMP_CHK: begin
				rd_q <= rd_q + 1'b1;
				if (!drop) begin
					wr_q <= wr_q + 1'b1;
				end
			end
			S_TICK_CHK: begin
				// head expired: report it, then shift the rest down by one
				if (!cmp_gt) begin
					fin_id_q <= ram_rdata.ident;
					rd_q     <= CW'(1);
					wr_q     <= '0;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_FIN && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && res_free) begin
			res_status_q <= fin_status_q;
			res_id_q     <= fin_id_q;
			res_count_q  <= PEND_W'(count_q);
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = res_status_q;
	assign expired_id    = res_id_q;
	assign pending_count = res_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("timer count above table depth");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q != S_IDLE)
		else $error("request taken but sequencer idle");

	a_ins_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> (pos_q != '0 && pos_q <= count_q))
		else $error("insert pointer out of range");

	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_EXPIRED) |-> expired_id == '0)
		else $error("expired id set without expiry");
`endif

endmodule

@@ verif/tb_sorted_expiry_timer_list.sv @@
// Testbench for the sorted expiry timer list: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

import setl_pkg::*;

typedef struct {
	status_t           status;
	logic [IDENT_W-1:0] expired_id;
	logic [PEND_W-1:0]  pending_count;
} timer_result_t;

// Scoreboard: mirrors the timer table and queues the result each request should give.
class timer_table_scoreboard;
	logic [EXPIRY_W-1:0] exp_tbl [TABLE_DEPTH_DEF];
	logic [IDENT_W-1:0]  id_tbl  [TABLE_DEPTH_DEF];
	int                  live;
	int                  errors;
	timer_result_t       awaited_results [$];

	function new();
		live = 0;
		errors = 0;
	endfunction

	function void drop_entry(int pos);
		for (int i = pos; i + 1 < live; i++) begin
			exp_tbl[i] = exp_tbl[i + 1];
			id_tbl[i]  = id_tbl[i + 1];
		end
		live--;
	endfunction

	function timer_result_t step_timer_table(action_t act, logic [EXPIRY_W-1:0] when,
			logic [IDENT_W-1:0] id, logic [EXPIRY_W-1:0] now);
		timer_result_t r;
		int pos;
		int i;
		bit hit;
		r.status = ST_NONE;
		r.expired_id = '0;
		case (act)
			ACT_INSERT: begin
				if (live >= TABLE_DEPTH_DEF) begin
					r.status = ST_FULL;
				end else begin
					// new entry goes after every entry due at or before it
					pos = 0;
					while (pos < live && exp_tbl[pos] <= when) pos++;
					for (i = live; i > pos; i--) begin
						exp_tbl[i] = exp_tbl[i - 1];
						id_tbl[i]  = id_tbl[i - 1];
					end
					exp_tbl[pos] = when;
					id_tbl[pos]  = id;
					live++;
					r.status = ST_ACCEPTED;
				end
			end
			ACT_CANCEL: begin
				i = 0;
				hit = 0;
				while (i < live) begin
					if (id_tbl[i] == id) begin
						drop_entry(i);
						hit = 1;
					end else begin
						i++;
					end
				end
				r.status = hit ? ST_ACCEPTED : ST_NONE;
			end
			ACT_TICK: begin
				if (live > 0 && now >= exp_tbl[0]) begin
					r.expired_id = id_tbl[0];
					drop_entry(0);
					r.status = ST_EXPIRED;
				end
			end
			default: ;
		endcase
		r.pending_count = PEND_W'(live);
		return r;
	endfunction

	function void note_request(logic [1:0] act, logic [EXPIRY_W-1:0] when,
			logic [IDENT_W-1:0] id, logic [EXPIRY_W-1:0] now);
		timer_result_t r;
		r = step_timer_table(action_t'(act), when, id, now);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function void check_result(logic [1:0] st, logic [IDENT_W-1:0] id, logic [PEND_W-1:0] cnt);
		timer_result_t e;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result status=%0d expired_id=%0h pending_count=%0d",
				$time, st, id, cnt);
			errors++;
			return;
		end
		e = awaited_results.pop_front();
		if (st !== e.status) begin
			$display("%0t: status expected %0d actual %0d", $time, e.status, st);
			errors++;
		end
		if (id !== e.expired_id) begin
			$display("%0t: expired_id expected %0h actual %0h", $time, e.expired_id, id);
			errors++;
		end
		if (cnt !== e.pending_count) begin
			$display("%0t: pending_count expected %0d actual %0d", $time, e.pending_count, cnt);
			errors++;
		end
	endfunction

	function int outstanding();
		return awaited_results.size();
	endfunction

	function void report_leftovers();
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected %0d but got none",
				$time, awaited_results.size(), awaited_results.size());
			errors++;
		end
	endfunction
endclass

module tb_sorted_expiry_timer_list;

	localparam int RANDOM_REQS     = 1325;
	localparam int LONG_HOLD_AT    = 300;   // result count at which the receiver holds off
	localparam int LONG_HOLD_LEN   = 400;
	localparam int IDLE_LIMIT      = 5000;  // cycles with no handshake before giving up
	localparam int SETTLE_CYCLES   = 2 * TABLE_DEPTH_DEF + 10;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [1:0]          action;
	logic [EXPIRY_W-1:0] expiry_time;
	logic [IDENT_W-1:0]  timer_id;
	logic [EXPIRY_W-1:0] now_seconds;
	logic                res_valid;
	logic                res_stall;
	logic [1:0]          status;
	logic [IDENT_W-1:0]  expired_id;
	logic [PEND_W-1:0]   pending_count;

	timer_table_scoreboard sb;
	bit sender_burst;
	bit receiver_burst;
	int results_taken;
	int idle_cycles;

	sorted_expiry_timer_list #(.TABLE_DEPTH(TABLE_DEPTH_DEF)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.expiry_time(expiry_time),
		.timer_id(timer_id),
		.now_seconds(now_seconds),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.expired_id(expired_id),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request after a random gap; hold it until the block takes it.
	// Valid stays high across back-to-back requests, so it is never dropped and
	// raised in the same step.
	task automatic send_request(input logic [1:0] act, input logic [EXPIRY_W-1:0] when,
			input logic [IDENT_W-1:0] id, input logic [EXPIRY_W-1:0] now);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid   <= 1'b1;
		action      <= act;
		expiry_time <= when;
		timer_id    <= id;
		now_seconds <= now;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		// noted here, not in a monitor, so the next random draw sees the updated table
		sb.note_request(act, when, id, now);
	endtask

	// Sender pause: stop offering and wait until every queued result has come back.
	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Receiver: random stall before each result, bursts with none, and one long
	// hold-off that lets the request side back up.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			if (results_taken % 64 == 0)
				receiver_burst = ($urandom_range(0, 3) == 0);
			if (results_taken == LONG_HOLD_AT)
				hold = LONG_HOLD_LEN;
			else
				hold = receiver_burst ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			sb.check_result(status, expired_id, pending_count);
			results_taken++;
		end
	end

	// Watchdog: any handshake on either side restarts the count.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int n;
		int mode;
		int roll;
		int pick;
		logic [1:0]          act;
		logic [EXPIRY_W-1:0] when;
		logic [IDENT_W-1:0]  id;
		logic [EXPIRY_W-1:0] now;
		logic [EXPIRY_W-1:0] now_base;

		sb = new();
		results_taken = 0;
		sender_burst = 0;
		receiver_burst = 0;
		mode = 0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		res_stall   = 1'b0;
		action      = ACT_NOP;
		expiry_time = '0;
		timer_id    = '0;
		now_seconds = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed part ----
		// empty table: tick, cancel that misses, no-op
		send_request(ACT_TICK,   32'd0, 16'd0, 32'd0);
		send_request(ACT_CANCEL, 32'd0, 16'd5, 32'd0);
		send_request(ACT_NOP,    '1,    '1,    '1);
		// equal expiries keep arrival order; extremes of expiry; id zero; duplicate id
		send_request(ACT_INSERT, 32'd100,      16'd1,      32'd0);
		send_request(ACT_INSERT, 32'd100,      16'd2,      32'd0);
		send_request(ACT_INSERT, 32'd0,        16'd3,      32'd0);
		send_request(ACT_INSERT, 32'hFFFFFFFF, 16'd4,      32'd0);
		send_request(ACT_INSERT, 32'd50,       16'd0,      32'd0);
		send_request(ACT_INSERT, 32'd100,      16'd1,      32'd0);
		// fill to capacity, then one insert that is refused
		for (n = 0; n < TABLE_DEPTH_DEF - 6; n++)
			send_request(ACT_INSERT, 32'h8000_0000 + 32'(n * 7), 16'hFFFF - 16'(n), 32'd0);
		send_request(ACT_INSERT, 32'd10, 16'hABCD, 32'd0);
		// head due at zero expires at now zero
		send_request(ACT_TICK,   32'd0, 16'd0, 32'd0);
		// head not yet due
		send_request(ACT_TICK,   32'd0, 16'd0, 32'd49);
		send_request(ACT_CANCEL, 32'd0, 16'd0, 32'd0);
		send_request(ACT_CANCEL, 32'd0, 16'd1, 32'd0);
		send_request(ACT_TICK,   32'd0, 16'd0, 32'hFFFFFFFF);
		send_request(ACT_NOP,    32'd0, 16'd0, 32'd0);
		wait_for_results();

		// ---- random part ----
		now_base = $urandom;
		for (n = 0; n < RANDOM_REQS; n++) begin
			if (n % 50 == 0) begin
				mode = $urandom_range(0, 2);
				sender_burst = ($urandom_range(0, 3) == 0);
			end
			if (n == RANDOM_REQS / 2)
				wait_for_results();
			// fields not used by the action carry junk
			when = $urandom;
			id   = 16'($urandom);
			now  = $urandom;
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				act = 2'($urandom_range(0, 3));
			end else begin
				roll = $urandom_range(0, 99);
				case (mode)
					0: act = (roll < 45) ? ACT_INSERT : (roll < 60) ? ACT_CANCEL :
						(roll < 95) ? ACT_TICK : ACT_NOP;
					1: act = (roll < 70) ? ACT_INSERT : (roll < 78) ? ACT_CANCEL :
						(roll < 97) ? ACT_TICK : ACT_NOP;
					default: act = (roll < 20) ? ACT_INSERT : (roll < 35) ? ACT_CANCEL :
						(roll < 97) ? ACT_TICK : ACT_NOP;
				endcase
				case (act)
					ACT_INSERT: begin
						pick = $urandom_range(0, 9);
						if (pick == 1 && sb.live > 0)
							when = sb.exp_tbl[$urandom_range(0, sb.live - 1)];
						else if (pick != 0)
							when = now_base + 32'($urandom_range(0, 40));
						pick = $urandom_range(0, 59);
						if (pick < 2 && sb.live > 0)
							id = sb.id_tbl[$urandom_range(0, sb.live - 1)];
						else if (pick == 2)
							id = '0;
						else
							id = 16'($urandom_range(1, 65535));
					end
					ACT_CANCEL: begin
						if (sb.live > 0 && $urandom_range(0, 9) < 7)
							id = sb.id_tbl[$urandom_range(0, sb.live - 1)];
					end
					ACT_TICK: begin
						pick = $urandom_range(0, 19);
						if (pick == 1) begin
							now = '0;
						end else if (pick == 2) begin
							now = '1;
						end else if (pick != 0) begin
							now_base = now_base + 32'($urandom_range(0, 2));
							now = now_base;
						end
					end
					default: ;
				endcase
			end
			send_request(act, when, id, now);
		end

		// ---- wrap up ----
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.report_leftovers();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
